// ===== rtl/core/mcbd_pkg.sv =====
`timescale 1ns / 1ps

package mcbd_pkg;

  localparam int CLASS_W = 6;
  localparam int ID_W = 16;
  localparam int CODE_W = 3;
  // Widest slot index over the whole depth range (depth up to 64)
  localparam int SLOT_MAX_W = 6;

  localparam int NUM_CLASSES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam logic [CODE_W-1:0] CODE_ACCEPTED = 3'd0;
  localparam logic [CODE_W-1:0] CODE_FULL = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SERVED = 3'd2;
  localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BAD_CLASS = 3'd4;

  typedef struct packed {
    logic op;
    logic [CLASS_W-1:0] class_index;
    logic [ID_W-1:0] item_id;
    logic urgent;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [ID_W-1:0] served_id;
    logic served_urgent;
  } out_item_t;

  // Lookup request into the queue table
  typedef struct packed {
    logic commit;
    logic op;
    logic urgent;
    logic [CLASS_W-1:0] class_index;
  } qtab_req_t;

  // Decision from the queue table
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic wr_en;
    logic rd_en;
    logic [SLOT_MAX_W-1:0] slot;
  } qtab_resp_t;

endpackage

// ===== rtl/core/mcbd_ram.sv =====
`timescale 1ns / 1ps

module mcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mcbd_qtab.sv =====
`timescale 1ns / 1ps

module mcbd_qtab #(
  parameter int NUM_CLASSES = mcbd_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = mcbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcbd_pkg::qtab_req_t   req,
  output mcbd_pkg::qtab_resp_t  resp
);

  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CLASS_LIM_W = mcbd_pkg::CLASS_W + 1;

  logic [SW-1:0] head_r [NUM_CLASSES];
  logic [CW-1:0] count_r [NUM_CLASSES];

  logic bad;
  logic [CLW-1:0] tidx;
  logic [SW-1:0] head_cur, head_dec, head_inc, tail, slot, head_nxt;
  logic [CW-1:0] cnt_cur, cnt_nxt;
  logic [SUMW-1:0] tail_sum;
  logic full, upd;

  assign bad = {1'b0, req.class_index} >= CLASS_LIM_W'(NUM_CLASSES);
  assign tidx = bad ? '0 : req.class_index[CLW-1:0];
  assign head_cur = head_r[tidx];
  assign cnt_cur = count_r[tidx];
  assign full = cnt_cur == CW'(QUEUE_DEPTH);

  // Circular slot arithmetic, one compare each
  assign head_dec = (head_cur == '0) ? SW'(QUEUE_DEPTH - 1) : head_cur - SW'(1);
  assign head_inc = (head_cur == SW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + SW'(1);
  assign tail_sum = SUMW'(head_cur) + SUMW'(cnt_cur);
  assign tail = (tail_sum >= SUMW'(QUEUE_DEPTH))
              ? SW'(tail_sum - SUMW'(QUEUE_DEPTH)) : SW'(tail_sum);

  always_comb begin
    resp.code = mcbd_pkg::CODE_BAD_CLASS;
    resp.wr_en = 1'b0;
    resp.rd_en = 1'b0;
    slot = '0;
    head_nxt = head_cur;
    cnt_nxt = cnt_cur;
    upd = 1'b0;
    if (bad) begin
      resp.code = mcbd_pkg::CODE_BAD_CLASS;
    end else if (req.op == mcbd_pkg::OP_ENQUEUE) begin
      if (full) begin
        resp.code = mcbd_pkg::CODE_FULL;
      end else begin
        resp.code = mcbd_pkg::CODE_ACCEPTED;
        resp.wr_en = req.commit;
        upd = req.commit;
        cnt_nxt = cnt_cur + CW'(1);
        if (req.urgent) begin
          head_nxt = head_dec;
          slot = head_dec;
        end else begin
          slot = tail;
        end
      end
    end else begin
      if (cnt_cur == '0) begin
        resp.code = mcbd_pkg::CODE_EMPTY;
      end else begin
        resp.code = mcbd_pkg::CODE_SERVED;
        resp.rd_en = req.commit;
        upd = req.commit;
        slot = head_cur;
        head_nxt = head_inc;
        cnt_nxt = cnt_cur - CW'(1);
      end
    end
    resp.slot = mcbd_pkg::SLOT_MAX_W'(slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else if (upd) begin
      head_r[tidx] <= head_nxt;
      count_r[tidx] <= cnt_nxt;
    end
  end

  a_no_rd_empty: assert property (@(posedge clk) disable iff (!rst_n)
    resp.rd_en |-> cnt_cur != '0 && !bad)
    else $error("serve read issued on empty or bad class");

  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    resp.wr_en |=> $past(cnt_cur) < CW'(QUEUE_DEPTH))
    else $error("enqueue write issued on full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_cur <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/multi_class_bounded_deque_core.sv =====
`timescale 1ns / 1ps
// An accepted item waits in the stage-1 register while the queue table decides
// it, then its result loads the result register when free. Throughput: 1 item
// per cycle unless out_stall holds a result; at most one RAM write or read per item.
// Reset (synchronous, active low) empties every class queue; entry storage is
// not cleared and is only read at occupied slots.
module multi_class_bounded_deque_core #(
  parameter int NUM_CLASSES = mcbd_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = mcbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcbd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcbd_pkg::out_item_t  out_item
);

  localparam int ENTRIES = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = mcbd_pkg::ID_W + 1;

  logic s1_valid_r;
  mcbd_pkg::in_item_t s1_item_r;
  logic out_valid_r;
  logic [mcbd_pkg::CODE_W-1:0] out_code_r;
  logic adv;

  mcbd_pkg::qtab_req_t req;
  mcbd_pkg::qtab_resp_t resp;

  logic [AW-1:0] mem_addr;
  logic [DW-1:0] ram_rdata;

  // Advance the pipeline whenever the result register is free or drained
  assign adv = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (adv && s1_valid_r) begin
      out_code_r <= resp.code;
    end
  end

  assign req.commit = s1_valid_r && adv;
  assign req.op = s1_item_r.op;
  assign req.urgent = s1_item_r.urgent;
  assign req.class_index = s1_item_r.class_index;

  mcbd_qtab #(
    .NUM_CLASSES(NUM_CLASSES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_qtab (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .resp (resp)
  );

  assign mem_addr = AW'(AW'(s1_item_r.class_index) * AW'(QUEUE_DEPTH)) + AW'(resp.slot);

  mcbd_ram #(
    .WIDTH(DW),
    .DEPTH(ENTRIES)
  ) u_entries (
    .clk  (clk),
    .we   (resp.wr_en),
    .waddr(mem_addr),
    .wdata({s1_item_r.item_id, s1_item_r.urgent}),
    .re   (resp.rd_en),
    .raddr(mem_addr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item.result_code = out_code_r;
  assign out_item.served_id = (out_code_r == mcbd_pkg::CODE_SERVED)
                            ? ram_rdata[DW-1:1] : '0;
  assign out_item.served_urgent = (out_code_r == mcbd_pkg::CODE_SERVED)
                                ? ram_rdata[0] : 1'b0;

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(resp.wr_en && resp.rd_en))
    else $error("entry RAM read and write in one cycle");

  a_serve_lands: assert property (@(posedge clk) disable iff (!rst_n)
    resp.rd_en |=> out_valid_r && out_code_r == mcbd_pkg::CODE_SERVED)
    else $error("served read did not reach result register");

  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(ram_rdata))
    else $error("entry read data changed under a stalled result");

  a_commit_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (resp.wr_en || resp.rd_en) |-> s1_valid_r && adv)
    else $error("entry access without an advancing item");

endmodule
